// ===== rtl/pha_pkg.sv =====
// Package for the pixel histogram accumulator.
// Holds the count and frame-size constants, register indexes and the side clamp.
// No dependencies.
package pha_pkg;

    localparam int COUNT_BITS    = 32;
    localparam int SIDE_BITS     = 13;
    localparam int SEEN_BITS     = 24;
    localparam int TOTAL_BITS    = 25;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [SIDE_BITS-1:0]  MAX_SIDE     = 13'd4096;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = 32'hFFFF_FFFF;
    localparam logic [SIDE_BITS-1:0]  WIDTH_RESET  = 13'd1920;
    localparam logic [SIDE_BITS-1:0]  HEIGHT_RESET = 13'd1080;
    localparam logic [TOTAL_BITS-1:0] TOTAL_RESET  = 25'd2073600;

    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_HEIGHT = 2'd1;

    localparam logic ACTION_COUNT = 1'b0;
    localparam logic ACTION_READ  = 1'b1;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [SIDE_BITS-1:0]  t_side;

    // A side of zero counts as one, and anything above 4096 as 4096.
    function automatic t_side clamp_side(input t_side v);
        t_side r;
        if (v == '0) begin
            r = t_side'(1);
        end else if (v > MAX_SIDE) begin
            r = MAX_SIDE;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/pixel_histogram_accumulator.sv =====
// Pixel histogram accumulator top level: bin store, read-modify-write pipeline,
// frame counter and configuration registers. Depends on pha_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_stall): each transaction is either a count
//   transaction (action 0), which adds one to the bin of i_in_pixel, or a read
//   transaction (action 1), which returns the count of bin i_in_bin_index and
//   zeroes that bin. Only the low PIXEL_BITS bits of pixel and bin_index are used.
//   Output channel (o_out_valid / i_out_stall): one result per input transaction,
//   in order. Count transactions return a count of zero and flag frame_done on the
//   last pixel of an active_width by active_height frame; read transactions
//   return the bin count with frame_done low. Counts saturate at all ones.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is
//   active_width, index 1 is active_height. Write only while the block is idle.
// Timing
//   An accepted transaction is held in stage 1 until its result enters the output register.
//   One transaction per cycle is sustained while the output is not stalled; the bin
//   store is read when a transaction is accepted and written back when it leaves
//   stage 1, and a write to the same bin is forwarded to the following transaction.
//   While the output register holds a stalled result the input is stalled as well.
// Reset
//   After reset the store is swept to zero, one bin per cycle, and the input
//   channel is stalled during the sweep.
module pixel_histogram_accumulator
    import pha_pkg::*;
#(
    parameter int PIXEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_in_action,
    input  logic [15:0]             i_in_pixel,
    input  logic [15:0]             i_in_bin_index,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [COUNT_BITS-1:0]   o_out_bin_count,
    output logic                    o_out_frame_done,

    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [SIDE_BITS-1:0]    i_cfg_data
);

    localparam int DEPTH = 2 ** PIXEL_BITS;

    // Bin store.
    t_count mem_bins [DEPTH];

    // Configuration and frame state.
    t_side                 r_width;
    t_side                 r_height;
    logic [TOTAL_BITS-1:0] r_total;
    logic [SEEN_BITS-1:0]  r_seen;
    logic [SEEN_BITS-1:0]  n_seen;

    // Clearing sweep.
    logic                  r_clr_active;
    logic [PIXEL_BITS-1:0] r_clr_addr;

    // Stage 1: read data is back from the store.
    logic                  r_s1_valid;
    logic                  r_s1_action;
    logic [PIXEL_BITS-1:0] r_s1_addr;
    t_count                r_rd_data;

    // Last write to the store, for forwarding.
    logic                  r_wb_valid;
    logic [PIXEL_BITS-1:0] r_wb_addr;
    t_count                r_wb_data;

    // Output register.
    logic                  r_out_valid;
    t_count                r_out_count;
    logic                  r_out_done;

    logic                  advance;
    logic                  in_accept;
    logic [PIXEL_BITS-1:0] in_addr;
    logic                  s1_fire;
    t_count                s1_old;
    t_count                n_bin;
    t_count                n_out_count;
    logic                  n_out_done;
    logic [TOTAL_BITS-1:0] seen_next;
    logic                  wr_en;
    logic [PIXEL_BITS-1:0] wr_addr;
    t_count                wr_data;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_clr_active || !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_addr     = (i_in_action == ACTION_READ) ? i_in_bin_index[PIXEL_BITS-1:0]
                                                      : i_in_pixel[PIXEL_BITS-1:0];
    assign s1_fire     = r_s1_valid && advance;
    assign o_cfg_ready = 1'b1;

    // The write of the previous transaction lands at the edge where this one was
    // read, so the store returns the old value; take the forwarded one instead.
    assign s1_old = (r_wb_valid && r_wb_addr == r_s1_addr) ? r_wb_data : r_rd_data;

    always_comb begin
        seen_next   = {1'b0, r_seen} + TOTAL_BITS'(1);
        n_seen      = r_seen;
        n_out_count = '0;
        n_out_done  = 1'b0;
        case (r_s1_action)
            ACTION_COUNT: begin
                n_bin = (s1_old == COUNT_MAX) ? s1_old : s1_old + t_count'(1);
                if (seen_next >= r_total) begin
                    n_out_done = 1'b1;
                    n_seen     = '0;
                end else begin
                    n_seen = seen_next[SEEN_BITS-1:0];
                end
            end
            ACTION_READ: begin
                n_bin       = '0;
                n_out_count = s1_old;
            end
            default: begin
                n_bin = s1_old;
            end
        endcase
    end

    always_comb begin
        if (r_clr_active) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = s1_fire;
            wr_addr = r_s1_addr;
            wr_data = n_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_bins[wr_addr] <= wr_data;
        end
        if (in_accept) begin
            r_rd_data <= mem_bins[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WIDTH_RESET;
            r_height     <= HEIGHT_RESET;
            r_total      <= TOTAL_RESET;
            r_seen       <= '0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_valid   <= 1'b0;
            r_wb_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_ACTIVE_WIDTH) begin
                    r_width <= i_cfg_data;
                end else if (i_cfg_index == REG_ACTIVE_HEIGHT) begin
                    r_height <= i_cfg_data;
                end
            end
            r_total <= TOTAL_BITS'(clamp_side(r_width)) * TOTAL_BITS'(clamp_side(r_height));

            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + PIXEL_BITS'(1);
                if (r_clr_addr == PIXEL_BITS'(DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end

            if (wr_en) begin
                r_wb_valid <= 1'b1;
            end

            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_out_valid <= 1'b1;
                if (r_s1_action == ACTION_COUNT) begin
                    r_seen <= n_seen;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wb_addr <= wr_addr;
            r_wb_data <= wr_data;
        end
        if (in_accept) begin
            r_s1_action <= i_in_action;
            r_s1_addr   <= in_addr;
        end
        if (s1_fire) begin
            r_out_count <= n_out_count;
            r_out_done  <= n_out_done;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_bin_count  = r_out_count;
    assign o_out_frame_done = r_out_done;

    a_clear_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> o_in_stall)
        else $error("input accepted during clearing sweep");

    a_no_work_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> (!r_s1_valid && !r_out_valid))
        else $error("pipeline busy during clearing sweep");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted transaction lost before stage 1");

    a_done_has_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_frame_done) |-> (o_out_bin_count == '0))
        else $error("frame_done result carries a bin count");

endmodule

// ===== sim/pixel_histogram_accumulator_tb.sv =====
// Self-checking testbench for the pixel histogram accumulator.
// Drives count, read and register transactions and checks each result against a
// predictor kept in the bench. Depends on pha_pkg and pixel_histogram_accumulator.
`timescale 1ns / 1ps

module pixel_histogram_accumulator_tb
    import pha_pkg::*;
();

    localparam int PIXEL_BITS = 16;
    localparam int unsigned BIN_MASK = (1 << PIXEL_BITS) - 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_PERCENT = 26;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        t_count count;
        logic   frame_done;
    } t_bin_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_in_action = ACTION_COUNT;
    logic [15:0]             i_in_pixel = '0;
    logic [15:0]             i_in_bin_index = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [COUNT_BITS-1:0]   o_out_bin_count;
    logic                    o_out_frame_done;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [SIDE_BITS-1:0]    i_cfg_data = '0;

    // Predictor state: one count per bin, the frame position and the frame size.
    bit [COUNT_BITS-1:0] model_bins [65536];
    int unsigned         model_seen = 0;
    logic [SIDE_BITS-1:0] model_width = WIDTH_RESET;
    logic [SIDE_BITS-1:0] model_height = HEIGHT_RESET;
    t_bin_result         awaited_results [$];

    bit idle_enable = 1'b1;
    int fault_count = 0;
    int results_seen = 0;
    int pixels_sent = 0;
    int reads_sent = 0;
    int frames_closed = 0;
    int settings_tried = 0;
    int cycle_count = 0;

    pixel_histogram_accumulator #(
        .PIXEL_BITS(PIXEL_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_action      (i_in_action),
        .i_in_pixel       (i_in_pixel),
        .i_in_bin_index   (i_in_bin_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_bin_count  (o_out_bin_count),
        .o_out_frame_done (o_out_frame_done),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, awaited_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= idle_enable && ($urandom_range(99) < IDLE_PERCENT);
    end

    // A side of zero behaves as one and anything past the maximum as the maximum.
    function automatic int unsigned effective_side(input logic [SIDE_BITS-1:0] side);
        if (side == '0) begin
            return 1;
        end
        if (side > MAX_SIDE) begin
            return 32'(MAX_SIDE);
        end
        return 32'(side);
    endfunction

    function automatic void histogram_predict(input logic action, input logic [15:0] pixel,
                                              input logic [15:0] bin_idx);
        t_bin_result r;
        int unsigned slot;
        int unsigned frame_size;
        int unsigned next_seen;
        r.count = '0;
        r.frame_done = 1'b0;
        if (action == ACTION_COUNT) begin
            slot = 32'(pixel) & BIN_MASK;
            frame_size = effective_side(model_width) * effective_side(model_height);
            next_seen = model_seen + 1;
            if (model_bins[slot] != COUNT_MAX) begin
                model_bins[slot] = model_bins[slot] + 1;
            end
            // A frame that shrank below the current position closes on the next pixel.
            if (next_seen >= frame_size) begin
                r.frame_done = 1'b1;
                model_seen = 0;
                frames_closed++;
            end else begin
                model_seen = next_seen;
            end
            pixels_sent++;
        end else begin
            slot = 32'(bin_idx) & BIN_MASK;
            r.count = model_bins[slot];
            model_bins[slot] = '0;
            reads_sent++;
        end
        awaited_results.push_back(r);
    endfunction

    // Called at a rising edge; returns at the edge where the transaction was taken.
    task automatic send_item(input logic action, input logic [15:0] pixel,
                             input logic [15:0] bin_idx);
        while (idle_enable && ($urandom_range(99) < IDLE_PERCENT)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_action <= action;
        i_in_pixel <= pixel;
        i_in_bin_index <= bin_idx;
        do @(posedge i_clk); while (o_in_stall);
        histogram_predict(action, pixel, bin_idx);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [SIDE_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_ACTIVE_WIDTH) begin
            model_width = value;
        end else if (idx == REG_ACTIVE_HEIGHT) begin
            model_height = value;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_pixel_extremes();
        send_item(ACTION_COUNT, 16'h0000, 16'hFFFF);
        send_item(ACTION_COUNT, 16'hFFFF, 16'h0000);
        send_item(ACTION_COUNT, 16'hFFFF, 16'h0000);
        send_item(ACTION_COUNT, 16'h5555, 16'hAAAA);
        send_item(ACTION_COUNT, 16'hAAAA, 16'h5555);
        send_item(ACTION_COUNT, 16'h0000, 16'h0000);
        send_item(ACTION_READ, 16'h0000, 16'hFFFF);
        send_item(ACTION_READ, 16'hFFFF, 16'hFFFF);
        send_item(ACTION_READ, 16'h0000, 16'h0000);
        // A read right behind a count of the same bin needs the forwarded value.
        send_item(ACTION_COUNT, 16'h5555, 16'h0000);
        send_item(ACTION_READ, 16'h0000, 16'h5555);
        send_item(ACTION_COUNT, 16'hAAAA, 16'h0000);
        send_item(ACTION_READ, 16'hFFFF, 16'hAAAA);
        send_item(ACTION_READ, 16'h0000, 16'h1234);
        wait_idle();
    endtask

    task automatic test_frame_boundaries();
        // Zero sides act as one, so every pixel closes a frame.
        write_reg(REG_ACTIVE_WIDTH, '0);
        write_reg(REG_ACTIVE_HEIGHT, '0);
        write_reg(REG_UNUSED, '1);
        settings_tried++;
        repeat (3) send_item(ACTION_COUNT, 16'($urandom), 16'($urandom));
        send_item(ACTION_READ, 16'($urandom), 16'($urandom));
        wait_idle();
        write_reg(REG_ACTIVE_WIDTH, 13'd3);
        write_reg(REG_ACTIVE_HEIGHT, 13'd3);
        settings_tried++;
        repeat (5) send_item(ACTION_COUNT, 16'h0F0F, 16'h0000);
        wait_idle();
        // Shrink the frame below the current position.
        write_reg(REG_ACTIVE_WIDTH, 13'd2);
        write_reg(REG_ACTIVE_HEIGHT, 13'd2);
        settings_tried++;
        send_item(ACTION_COUNT, 16'hF0F0, 16'h0000);
        repeat (4) send_item(ACTION_COUNT, 16'h0F0F, 16'h0000);
        send_item(ACTION_READ, 16'h0000, 16'h0F0F);
        wait_idle();
    endtask

    task automatic run_random_phase(input logic [SIDE_BITS-1:0] width,
                                    input logic [SIDE_BITS-1:0] height,
                                    input int items, input bit quiet);
        logic [15:0] hot [8];
        logic [15:0] value;
        write_reg(REG_ACTIVE_WIDTH, width);
        write_reg(REG_ACTIVE_HEIGHT, height);
        settings_tried++;
        idle_enable = !quiet;
        foreach (hot[k]) hot[k] = 16'($urandom);
        // Most traffic lands on a few hot bins so reads return real counts.
        repeat (items) begin
            value = ($urandom_range(99) < 65) ? hot[$urandom_range(7)] : 16'($urandom);
            if ($urandom_range(99) < 25) begin
                send_item(ACTION_READ, 16'($urandom), value);
            end else begin
                send_item(ACTION_COUNT, value, 16'($urandom));
            end
        end
        foreach (hot[k]) send_item(ACTION_READ, 16'($urandom), hot[k]);
        wait_idle();
        idle_enable = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_random_phase(13'd8191, 13'd0, 250, 1'b0);
        run_random_phase(13'd1, 13'd8191, 250, 1'b0);
        run_random_phase(MAX_SIDE, 13'd1, 250, 1'b0);
        run_random_phase(MAX_SIDE, MAX_SIDE, 200, 1'b0);
        run_random_phase(13'($urandom_range(1, 16)), 13'($urandom_range(1, 16)), 250, 1'b0);
        run_random_phase(13'($urandom), 13'($urandom), 200, 1'b0);
        run_random_phase(13'd0, 13'd1, 300, 1'b1);
        run_random_phase(13'($urandom_range(1, 8)), 13'($urandom_range(1, 8)), 250, 1'b0);
    endtask

    always @(posedge i_clk) begin : result_check
        t_bin_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("Unexpected result %0d: bin_count %h frame_done %b",
                             results_seen, o_out_bin_count, o_out_frame_done);
                end
            end else begin
                want = awaited_results.pop_front();
                if (o_out_bin_count !== want.count || o_out_frame_done !== want.frame_done) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("Mismatch on result %0d: bin_count exp %h got %h, %s",
                                 results_seen, want.count, o_out_bin_count,
                                 $sformatf("frame_done exp %b got %b",
                                           want.frame_done, o_out_frame_done));
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_pixel_extremes();
        test_frame_boundaries();
        test_random_traffic();
        wait_idle();
        if (awaited_results.size() != 0) begin
            fault_count++;
        end
        $display("Sent %0d pixel and %0d read transactions; %0d results checked.",
                 pixels_sent, reads_sent, results_seen);
        $display("Frame sizes tried: %0d; frames closed: %0d; faults: %0d.",
                 settings_tried, frames_closed, fault_count);
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pha_pkg.sv
rtl/pixel_histogram_accumulator.sv
sim/pixel_histogram_accumulator_tb.sv
